[src/wc2d_pkg.sv]
// shared constants, codes and types for the 2d window convolution
`timescale 1ns / 1ps

package wc2d_pkg;

    // pixel and field widths
    localparam int PIX_W     = 8;
    localparam int GEOM_W    = 11;
    localparam int ROW_W     = 10;
    localparam int OCOL_W    = 10;
    localparam int OROW_W    = 10;
    localparam int IDATA_W   = 8;
    localparam int ODATA_W   = 32;
    localparam int MAX_HEIGHT = 1024;

    // kernel register layout: three registers of three signed bytes
    localparam int KREG_W     = 24;
    localparam int NUM_KREG   = 3;
    localparam int KREG_BYTES = 3;
    localparam int KWORDS     = NUM_KREG * KREG_BYTES;

    // configuration port
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 24;

    localparam logic [CFG_IDX_W-1:0] REG_LINE_WIDTH   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KERNEL_ZERO  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_KERNEL_ONE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_KERNEL_TWO   = 3'd4;

    localparam logic [GEOM_W-1:0] LINE_WIDTH_RESET   = 11'd1024;
    localparam logic [GEOM_W-1:0] FRAME_HEIGHT_RESET = 11'd1024;

    // default parameter values
    localparam int DEF_KERNEL_SIZE = 3;
    localparam int DEF_MAX_WIDTH   = 1024;

    // per-cycle controls handed to every window cell
    typedef struct packed {
        logic shift;   // take the column from the right-hand neighbor
        logic calc;    // register this cell's column dot product
    } cell_ctrl_t;

    // result bookkeeping that travels with a word down the pipeline
    typedef struct packed {
        logic              emit;
        logic              done;
        logic [OCOL_W-1:0] ocol;
        logic [OROW_W-1:0] orow;
    } meta_t;

endpackage

[src/wc2d_line_store.sv]
// line store memory: one read port and one write port, registered read
`timescale 1ns / 1ps

module wc2d_line_store
    import wc2d_pkg::*;
#(
    parameter int DEPTH = DEF_MAX_WIDTH,
    parameter int WIDTH = PIX_W * (DEF_KERNEL_SIZE - 1)
)
(
    input  logic                     clk,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // read first: a same-address write lands after the read
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[src/wc2d_cell.sv]
// one window column: holds the pixels of one column offset and its partial sum
`timescale 1ns / 1ps

module wc2d_cell
    import wc2d_pkg::*;
#(
    parameter int KERNEL_SIZE = DEF_KERNEL_SIZE
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  cell_ctrl_t                        ctrl,
    input  logic [KERNEL_SIZE-1:0][PIX_W-1:0] col_in,
    input  logic [KERNEL_SIZE-1:0][PIX_W-1:0] coef,
    output logic [KERNEL_SIZE-1:0][PIX_W-1:0] col_out,
    output logic [PIX_W-1:0]                  part_out
);

    logic [KERNEL_SIZE-1:0][PIX_W-1:0] col_reg;
    logic [PIX_W-1:0]                  part_reg;
    logic [PIX_W-1:0]                  part_next;

    // column dot product, kept to the low byte since the result wraps
    always_comb
    begin
        logic signed [2*PIX_W-1:0] prod;
        part_next = '0;
        for (int dy = 0; dy < KERNEL_SIZE; dy++)
        begin
            prod      = $signed(col_reg[dy]) * $signed(coef[dy]);
            part_next = part_next + prod[PIX_W-1:0];
        end
    end

    // column shifts in from the neighbor
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
        end
        else if (ctrl.shift)
        begin
            col_reg <= col_in;
        end
    end

    // partial sum register
    always_ff @(posedge clk)
    begin
        if (ctrl.calc)
        begin
            part_reg <= part_next;
        end
    end

    assign col_out  = col_reg;
    assign part_out = part_reg;

endmodule

[src/window_convolution_2d.sv]
// top level: streaming 2d window convolution over signed 8-bit pixels
//
// Pixels enter on the s_ group in raster order, one word per accepted
// handshake. Each pixel whose window lies wholly inside the frame yields one
// result word on the m_ group: the low byte of the window sum of products,
// the column and row of the window's top-left corner, and tlast on the last
// result of a frame. Pixels near the top and left edges yield no word.
// Throughput is one pixel per cycle while the output is not stalled: the line
// store is read and written once per pixel, and the row of window cells shifts
// one column per pixel. An accepted pixel passes line store read, window cell
// shift, window cell products and final add into the output register in turn.
// When the receiver stalls, every pipeline stage holds and s_tready drops
// until the output word is taken; a word may be accepted in the same cycle
// the output word leaves.
// Reset clears the counters, the window, the pipeline and the registers
// (line width and frame height 1024, kernel zero). The line store is not
// cleared; stale entries reach no emitted word. The user writes configuration
// through cfg_we, cfg_index and cfg_data while idle; the block does not check.
`timescale 1ns / 1ps

module window_convolution_2d
    import wc2d_pkg::*;
#(
    parameter int KERNEL_SIZE = DEF_KERNEL_SIZE,
    parameter int MAX_WIDTH   = DEF_MAX_WIDTH
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    // pixel input
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [IDATA_W-1:0]   s_tdata,   // [7:0] pixel
    // result output
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [ODATA_W-1:0]   m_tdata,   // [7:0] filtered, [17:8] out_col,
                                            // [27:18] out_row, [31:28] zero
    output logic                 m_tlast,   // frame_done
    // configuration
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    localparam int KM1 = KERNEL_SIZE - 1;
    localparam int NL  = (KERNEL_SIZE > 1) ? KERNEL_SIZE - 1 : 1;
    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int WW  = (CW + 1 > GEOM_W) ? CW + 1 : GEOM_W;

    // configuration registers
    logic [GEOM_W-1:0]                 line_width_reg;
    logic [GEOM_W-1:0]                 frame_height_reg;
    logic [NUM_KREG-1:0][KREG_W-1:0]   kernel_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_width_reg   <= LINE_WIDTH_RESET;
            frame_height_reg <= FRAME_HEIGHT_RESET;
            kernel_reg       <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_LINE_WIDTH:   line_width_reg   <= cfg_data[GEOM_W-1:0];
                REG_FRAME_HEIGHT: frame_height_reg <= cfg_data[GEOM_W-1:0];
                REG_KERNEL_ZERO:  kernel_reg[0]    <= cfg_data[KREG_W-1:0];
                REG_KERNEL_ONE:   kernel_reg[1]    <= cfg_data[KREG_W-1:0];
                REG_KERNEL_TWO:   kernel_reg[2]    <= cfg_data[KREG_W-1:0];
                default:          ;
            endcase
        end
    end

    // effective geometry with out-of-range values clamped
    logic [WW-1:0]     width_ext;
    logic [WW-1:0]     width_eff;
    logic [GEOM_W-1:0] height_eff;

    always_comb
    begin
        width_ext = WW'(line_width_reg);
        if (width_ext == '0)
            width_eff = WW'(1);
        else if (width_ext > WW'(MAX_WIDTH))
            width_eff = WW'(MAX_WIDTH);
        else
            width_eff = width_ext;

        if (frame_height_reg == '0)
            height_eff = GEOM_W'(1);
        else if (frame_height_reg > GEOM_W'(MAX_HEIGHT))
            height_eff = GEOM_W'(MAX_HEIGHT);
        else
            height_eff = frame_height_reg;
    end

    // kernel coefficients per window position
    logic [KERNEL_SIZE-1:0][KERNEL_SIZE-1:0][PIX_W-1:0] coef;

    for (genvar dx = 0; dx < KERNEL_SIZE; dx++)
    begin : g_coef_x
        for (genvar dy = 0; dy < KERNEL_SIZE; dy++)
        begin : g_coef_y
            localparam int WORD = dx * KERNEL_SIZE + dy;
            if (WORD < KWORDS)
            begin : g_word
                localparam int RI = WORD / KREG_BYTES;
                localparam int BI = WORD % KREG_BYTES;
                assign coef[dx][dy] = kernel_reg[RI][BI*PIX_W +: PIX_W];
            end
            else
            begin : g_zero
                assign coef[dx][dy] = '0;
            end
        end
    end

    // pipeline advance: everything moves unless the output word is stuck
    logic adv;
    logic s_accept;

    assign adv      = !m_tvalid || m_tready;
    assign s_tready = adv;
    assign s_accept = s_tvalid && adv;

    // raster counters
    logic [CW-1:0]     col_reg;
    logic [ROW_W-1:0]  row_reg;
    logic [WW-1:0]     col_p1;
    logic [GEOM_W-1:0] row_p1;
    logic              col_wrap;
    logic              row_wrap;
    meta_t             meta0;

    always_comb
    begin
        col_p1     = WW'(col_reg) + WW'(1);
        row_p1     = GEOM_W'(row_reg) + GEOM_W'(1);
        col_wrap   = col_p1 >= width_eff;
        row_wrap   = row_p1 >= height_eff;
        meta0.emit = (col_reg >= CW'(KM1)) && (row_reg >= ROW_W'(KM1));
        meta0.done = col_wrap && row_wrap;
        meta0.ocol = OCOL_W'(col_reg - CW'(KM1));
        meta0.orow = OROW_W'(row_reg - ROW_W'(KM1));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (s_accept)
        begin
            if (col_wrap)
            begin
                col_reg <= '0;
                row_reg <= row_wrap ? '0 : row_p1[ROW_W-1:0];
            end
            else
            begin
                col_reg <= col_p1[CW-1:0];
            end
        end
    end

    // stage 1: pixel waits for the line store read
    logic                   v1_reg;
    logic [PIX_W-1:0]       p1_reg;
    logic [CW-1:0]          a1_reg;
    meta_t                  m1_reg;
    logic                   byp_reg;
    logic [NL-1:0][PIX_W-1:0] byp_data_reg;
    logic [NL-1:0][PIX_W-1:0] rd_data;
    logic [NL-1:0][PIX_W-1:0] rd_fwd;
    logic [NL-1:0][PIX_W-1:0] wr_data;
    logic [NL:0][PIX_W-1:0]   new_col;
    logic                   wr_en;

    // a same-cycle write to the read address is forwarded
    assign rd_fwd = byp_reg ? byp_data_reg : rd_data;

    // new window column: stored rows on top, fresh pixel at the bottom
    always_comb
    begin
        for (int i = 0; i <= NL; i++)
        begin
            if (i < KM1)
                new_col[i] = rd_fwd[i];
            else if (i == KM1)
                new_col[i] = p1_reg;
            else
                new_col[i] = '0;
        end
        for (int i = 0; i < NL; i++)
        begin
            wr_data[i] = new_col[i+1];
        end
    end

    assign wr_en = v1_reg && adv;

    wc2d_line_store #(
        .DEPTH (MAX_WIDTH),
        .WIDTH (NL * PIX_W)
    ) u_line_store (
        .clk     (clk),
        .rd_en   (s_accept),
        .rd_addr (col_reg),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (a1_reg),
        .wr_data (wr_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg  <= 1'b0;
            byp_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg  <= s_accept;
            byp_reg <= s_accept && v1_reg && (a1_reg == col_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            byp_data_reg <= wr_data;
        end
        if (s_accept)
        begin
            p1_reg <= s_tdata[PIX_W-1:0];
            a1_reg <= col_reg;
            m1_reg <= meta0;
        end
    end

    // stage 2 and 3 bookkeeping
    logic  v2_reg;
    logic  v3_reg;
    meta_t m2_reg;
    meta_t m3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (adv)
        begin
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m2_reg <= m1_reg;
            m3_reg <= m2_reg;
        end
    end

    // row of window cells, column data moving right to left
    cell_ctrl_t                                        cell_ctrl;
    logic [KERNEL_SIZE-1:0][KERNEL_SIZE-1:0][PIX_W-1:0] cell_col;
    logic [KERNEL_SIZE-1:0][PIX_W-1:0]                 cell_part;

    assign cell_ctrl.shift = v1_reg && adv;
    assign cell_ctrl.calc  = v2_reg && adv;

    for (genvar dx = 0; dx < KERNEL_SIZE; dx++)
    begin : g_cell
        logic [KERNEL_SIZE-1:0][PIX_W-1:0] col_in;
        if (dx == KERNEL_SIZE - 1)
        begin : g_feed
            assign col_in = new_col[KERNEL_SIZE-1:0];
        end
        else
        begin : g_link
            assign col_in = cell_col[dx+1];
        end

        wc2d_cell #(
            .KERNEL_SIZE (KERNEL_SIZE)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctrl     (cell_ctrl),
            .col_in   (col_in),
            .coef     (coef[dx]),
            .col_out  (cell_col[dx]),
            .part_out (cell_part[dx])
        );
    end

    // final add of the column partials
    logic [PIX_W-1:0] sum_next;

    always_comb
    begin
        sum_next = '0;
        for (int dx = 0; dx < KERNEL_SIZE; dx++)
        begin
            sum_next = sum_next + cell_part[dx];
        end
    end

    // output register
    logic               out_valid_reg;
    logic [ODATA_W-1:0] out_data_reg;
    logic               out_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= v3_reg && m3_reg.emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_data_reg <= ODATA_W'({m3_reg.orow, m3_reg.ocol, sum_next});
            out_last_reg <= m3_reg.done;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

    // pipeline holds as a whole while the output is stalled
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(v1_reg) && $stable(v2_reg) && $stable(v3_reg))
        else $error("pipeline moved during a stall");

    // an accepted pixel that yields a result enters stage 1 marked so
    a_emit_entry: assert property (@(posedge clk) disable iff (!rst_n)
        s_accept && meta0.emit |=> v1_reg && m1_reg.emit)
        else $error("emitting pixel lost on entry");

    // a new output word comes only from a valid emitting stage 3 word
    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(v3_reg && m3_reg.emit))
        else $error("output word without a source");

    // forwarding only ever applies to a word sitting in stage 1
    a_bypass_owner: assert property (@(posedge clk) disable iff (!rst_n)
        byp_reg |-> v1_reg)
        else $error("line store forward without a stage 1 word");

endmodule
